>>> sv/stereo_correlation_meter_top_defines.svh
// Assertion macros shared by the stereo correlation meter RTL.
`ifndef STEREO_CORRELATION_METER_TOP_DEFINES_SVH
`define STEREO_CORRELATION_METER_TOP_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define SCM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("scm assertion failed");

// Check that a condition implies another at the same clock edge.
`define SCM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scm assertion failed");

`endif

>>> sv/scm_pkg.sv
// Shared types and constants of the stereo correlation meter.
package scm_pkg;

  localparam int HIST_DEPTH = 40;
  localparam int HIST_IDX_W = 6;
  localparam int CNT_W      = 6;
  localparam int MAX_CH     = 8;
  localparam int MAX_FRAMES = 65536;
  localparam int FRAME_W    = 17;
  localparam int SAMPLE_W   = 24;
  localparam int ACC_W      = 64;
  localparam int TOTAL_W    = 22;
  localparam int RES_W      = 16;

  typedef enum logic [1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_X_CHANNEL     = 2'd1,
    CFG_Y_CHANNEL     = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [ACC_W-1:0]         ex;
    logic [ACC_W-1:0]         ey;
    logic signed [ACC_W-1:0]  cs;
  } job_t;

endpackage

>>> sv/stereo_correlation_meter_top.sv
// Stereo correlation meter: top level joining front end, job queue and back end.
//
// Samples are taken one per cycle while the job queue is not full; the front
// end picks the two measured channels out of each interleaved frame and sums
// both energies and the cross product. A clear item or the sample that closes a
// buffer places one job in a two-entry queue, and the front end stalls only
// while that queue is full. The back end runs each buffer job through one serial
// divider (one quotient bit a cycle) and one serial square root (one result bit
// a cycle): normalization (k two-bit shifts over both energies, 0 to 60), the
// two roots, the correlation divide, the balance divide and root, the history
// update and the history mean, then holds the result while the output stalls;
// a buffer with a zero energy skips normalization, the roots and the
// correlation divide. A clear job only resets the history. Configuration
// writes are always accepted.
module stereo_correlation_meter_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic signed [23:0]  in_sample,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_correlation,
  output logic signed [15:0]  out_balance,
  output logic signed [15:0]  out_mean_correlation,
  output logic [5:0]          out_history_fill
);
  import scm_pkg::*;

  logic job_push;
  job_t push_job;
  logic job_full;
  logic job_pop;
  logic job_valid;
  job_t pop_job;

  scm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .in_sample (in_sample),
    .in_last   (in_last),
    .job_valid (job_push),
    .job       (push_job),
    .job_full  (job_full)
  );

  scm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_job),
    .full      (job_full),
    .pop       (job_pop),
    .pop_valid (job_valid),
    .pop_data  (pop_job)
  );

  scm_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .job_valid            (job_valid),
    .job                  (pop_job),
    .job_pop              (job_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_correlation      (out_correlation),
    .out_balance          (out_balance),
    .out_mean_correlation (out_mean_correlation),
    .out_history_fill     (out_history_fill)
  );

endmodule

>>> sv/scm_front.sv
// Front end: configuration, channel selection and per-buffer accumulation.
module scm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic signed [23:0]  in_sample,
  input  logic                in_last,
  output logic                job_valid,
  output scm_pkg::job_t       job,
  input  logic                job_full
);
  import scm_pkg::*;

  logic [3:0]                 chan_cnt_r;
  logic [2:0]                 x_ch_r;
  logic [2:0]                 y_ch_r;
  logic [2:0]                 pos_r;
  logic signed [SAMPLE_W-1:0] hx_r;
  logic signed [SAMPLE_W-1:0] hy_r;
  logic [ACC_W-1:0]           ex_r;
  logic [ACC_W-1:0]           ey_r;
  logic signed [ACC_W-1:0]    cs_r;
  logic [FRAME_W-1:0]         fc_r;

  logic [3:0]                 cc;
  logic [2:0]                 pos_eff;
  logic signed [SAMPLE_W-1:0] hx_nxt;
  logic signed [SAMPLE_W-1:0] hy_nxt;
  logic                       frame_end;
  logic                       do_acc;
  logic signed [2*SAMPLE_W-1:0] pxx;
  logic signed [2*SAMPLE_W-1:0] pyy;
  logic signed [2*SAMPLE_W-1:0] pxy;
  logic [ACC_W-1:0]           ex_nxt;
  logic [ACC_W-1:0]           ey_nxt;
  logic signed [ACC_W-1:0]    cs_nxt;
  logic                       accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = job_full;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    if (chan_cnt_r == 4'd0) begin
      cc = 4'd1;
    end else if (chan_cnt_r > 4'(MAX_CH)) begin
      cc = 4'(MAX_CH);
    end else begin
      cc = chan_cnt_r;
    end
    pos_eff   = ({1'b0, pos_r} >= cc) ? 3'd0 : pos_r;
    hx_nxt    = (pos_eff == x_ch_r) ? in_sample : hx_r;
    hy_nxt    = (pos_eff == y_ch_r) ? in_sample : hy_r;
    frame_end = ({1'b0, pos_eff} == (cc - 4'd1)) || in_last;
    do_acc    = frame_end && (fc_r < FRAME_W'(MAX_FRAMES));
    pxx       = hx_nxt * hx_nxt;
    pyy       = hy_nxt * hy_nxt;
    pxy       = hx_nxt * hy_nxt;
    ex_nxt    = do_acc ? (ex_r + ACC_W'($unsigned(pxx))) : ex_r;
    ey_nxt    = do_acc ? (ey_r + ACC_W'($unsigned(pyy))) : ey_r;
    cs_nxt    = do_acc ? (cs_r + ACC_W'(pxy)) : cs_r;
  end

  assign job_valid = accept && ((in_kind == KIND_CLEAR) || in_last);
  assign job.kind  = kind_t'(in_kind);
  assign job.ex    = ex_nxt;
  assign job.ey    = ey_nxt;
  assign job.cs    = cs_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= 4'd2;
      x_ch_r     <= 3'd0;
      y_ch_r     <= 3'd1;
      pos_r      <= '0;
      hx_r       <= '0;
      hy_r       <= '0;
      ex_r       <= '0;
      ey_r       <= '0;
      cs_r       <= '0;
      fc_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_CHANNEL_COUNT: chan_cnt_r <= cfg_data;
          CFG_X_CHANNEL:     x_ch_r     <= cfg_data[2:0];
          CFG_Y_CHANNEL:     y_ch_r     <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (accept && (in_kind == KIND_SAMPLE)) begin
        if (frame_end) begin
          pos_r <= '0;
          hx_r  <= '0;
          hy_r  <= '0;
        end else begin
          pos_r <= pos_eff + 3'd1;
          hx_r  <= hx_nxt;
          hy_r  <= hy_nxt;
        end
        if (in_last) begin
          ex_r <= '0;
          ey_r <= '0;
          cs_r <= '0;
          fc_r <= '0;
        end else begin
          ex_r <= ex_nxt;
          ey_r <= ey_nxt;
          cs_r <= cs_nxt;
          if (do_acc) begin
            fc_r <= fc_r + FRAME_W'(1);
          end
        end
      end
    end
  end

endmodule

>>> sv/scm_fifo.sv
// Two-entry job queue between the front end and the arithmetic back end.
module scm_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  scm_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output scm_pkg::job_t pop_data
);
  import scm_pkg::*;

  job_t       mem [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = mem[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> sv/scm_back.sv
// Back end: serial square root and division, history ring and result register.
`include "stereo_correlation_meter_top_defines.svh"
module scm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  scm_pkg::job_t       job,
  output logic                job_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_correlation,
  output logic signed [15:0]  out_balance,
  output logic signed [15:0]  out_mean_correlation,
  output logic [5:0]          out_history_fill
);
  import scm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_SQRT, S_MUL, S_DIV, S_BALP, S_HREAD, S_HUPD, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    P_SX, P_SY, P_CORR, P_BDIV, P_BSQ, P_MEAN
  } phase_t;

  state_t                    state_r;
  phase_t                    ph_r;
  logic [ACC_W-1:0]          ex_r, ey_r, ax_r, ay_r;
  logic signed [ACC_W-1:0]   cs_r;
  logic [5:0]                k_r;
  logic [31:0]               sx_r, sy_r;
  logic [ACC_W-1:0]          dvd_r, dn_r, rem_r;
  logic [31:0]               q_r;
  logic                      ovf_r;
  logic [7:0]                it_r;
  logic                      neg_r;
  logic                      yl_r;
  logic [ACC_W-1:0]          sv_r, sr_r;
  logic [4:0]                si_r;
  logic signed [RES_W-1:0]   corr_r, bal_r, rd_r;
  logic [HIST_IDX_W-1:0]     head_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [TOTAL_W-1:0] total_r;
  logic                      out_valid_r;
  logic signed [RES_W-1:0]   ring [HIST_DEPTH];

  logic [ACC_W-1:0]          sbit, st, sv_nxt, sr_nxt;
  logic [ACC_W:0]            rs;
  logic                      ge;
  logic [ACC_W-1:0]          rem_nxt;
  logic [31:0]               q_nxt;
  logic                      ovf_nxt;
  logic signed [16:0]        negq;
  logic                      hfull;
  logic signed [TOTAL_W-1:0] total_nxt, total_abs;
  logic [CNT_W-1:0]          cnt_nxt;
  logic [16:0]               bmag;

  assign job_pop              = (state_r == S_IDLE) && job_valid;
  assign out_valid            = out_valid_r;
  assign out_history_fill     = cnt_r;

  always_comb begin
    sbit = ACC_W'(1) << (6'd62 - {si_r, 1'b0});
    st   = sr_r + sbit;
    if (sv_r >= st) begin
      sv_nxt = sv_r - st;
      sr_nxt = (sr_r >> 1) + sbit;
    end else begin
      sv_nxt = sv_r;
      sr_nxt = sr_r >> 1;
    end
    rs      = {rem_r, dn_r[ACC_W-1]};
    ge      = rs >= {1'b0, dvd_r};
    rem_nxt = ge ? ACC_W'(rs - {1'b0, dvd_r}) : rs[ACC_W-1:0];
    q_nxt   = {q_r[30:0], ge};
    ovf_nxt = ovf_r | q_r[31];
    negq    = 17'sd0 - $signed({1'b0, q_nxt[15:0]});
    hfull   = (cnt_r == CNT_W'(HIST_DEPTH));
    total_nxt = total_r - (hfull ? TOTAL_W'(rd_r) : TOTAL_W'(0)) + TOTAL_W'(corr_r);
    total_abs = (total_nxt < 0) ? -total_nxt : total_nxt;
    cnt_nxt   = hfull ? cnt_r : cnt_r + CNT_W'(1);
    bmag      = 17'd32768 - sr_nxt[16:0];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_HREAD) begin
      rd_r <= ring[head_r];
    end
    if (state_r == S_HUPD) begin
      ring[head_r] <= corr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= P_SX;
      head_r      <= '0;
      cnt_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            if (job.kind == KIND_CLEAR) begin
              head_r  <= '0;
              cnt_r   <= '0;
              total_r <= '0;
            end else begin
              ex_r <= job.ex;
              ey_r <= job.ey;
              ax_r <= job.ex;
              ay_r <= job.ey;
              cs_r <= job.cs;
              k_r  <= '0;
              if ((job.ex == '0) || (job.ey == '0)) begin
                corr_r  <= '0;
                state_r <= S_BALP;
              end else begin
                state_r <= S_NORM;
              end
            end
          end
        end
        S_NORM: begin
          if (ax_r < (ACC_W'(1) << 60)) begin
            ax_r <= ax_r << 2;
            k_r  <= k_r + 6'd1;
          end else if (ay_r < (ACC_W'(1) << 60)) begin
            ay_r <= ay_r << 2;
            k_r  <= k_r + 6'd1;
          end else begin
            sv_r    <= ax_r;
            sr_r    <= '0;
            si_r    <= '0;
            ph_r    <= P_SX;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          sv_r <= sv_nxt;
          sr_r <= sr_nxt;
          si_r <= si_r + 5'd1;
          if (si_r == 5'd31) begin
            priority case (ph_r)
              P_SX: begin
                sx_r <= sr_nxt[31:0];
                sv_r <= ay_r;
                sr_r <= '0;
                ph_r <= P_SY;
              end
              P_SY: begin
                sy_r    <= sr_nxt[31:0];
                state_r <= S_MUL;
              end
              default: begin
                if (yl_r) begin
                  bal_r <= (bmag > 17'd32767) ? 16'sd32767 : $signed(bmag[15:0]);
                end else begin
                  bal_r <= $signed(16'(sr_nxt[16:0] - 17'd32768));
                end
                state_r <= S_HREAD;
              end
            endcase
          end
        end
        S_MUL: begin
          dvd_r   <= sx_r * sy_r;
          dn_r    <= (cs_r < 0) ? ACC_W'(-cs_r) : ACC_W'(cs_r);
          neg_r   <= cs_r < 0;
          rem_r   <= '0;
          q_r     <= '0;
          ovf_r   <= 1'b0;
          it_r    <= 8'd79 + 8'(k_r);
          ph_r    <= P_CORR;
          state_r <= S_DIV;
        end
        S_DIV: begin
          dn_r  <= dn_r << 1;
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
          ovf_r <= ovf_nxt;
          it_r  <= it_r - 8'd1;
          if (it_r == 8'd1) begin
            priority case (ph_r)
              P_CORR: begin
                if (neg_r) begin
                  corr_r <= (ovf_nxt || (q_nxt > 32'd32768)) ? -16'sd32768 : negq[15:0];
                end else begin
                  corr_r <= (ovf_nxt || (q_nxt > 32'd32767)) ? 16'sd32767
                                                            : $signed(q_nxt[15:0]);
                end
                state_r <= S_BALP;
              end
              P_BDIV: begin
                sv_r    <= ACC_W'(q_nxt);
                sr_r    <= '0;
                si_r    <= '0;
                ph_r    <= P_BSQ;
                state_r <= S_SQRT;
              end
              default: begin
                out_valid_r <= 1'b1;
                state_r     <= S_OUT;
              end
            endcase
          end
        end
        S_BALP: begin
          if ((ex_r == '0) && (ey_r == '0)) begin
            bal_r   <= '0;
            state_r <= S_HREAD;
          end else begin
            yl_r    <= ey_r > ex_r;
            dn_r    <= (ey_r > ex_r) ? ex_r : ey_r;
            dvd_r   <= (ey_r > ex_r) ? ey_r : ex_r;
            rem_r   <= '0;
            q_r     <= '0;
            ovf_r   <= 1'b0;
            it_r    <= 8'd94;
            ph_r    <= P_BDIV;
            state_r <= S_DIV;
          end
        end
        S_HREAD: begin
          state_r <= S_HUPD;
        end
        S_HUPD: begin
          total_r <= total_nxt;
          cnt_r   <= cnt_nxt;
          head_r  <= (head_r == HIST_IDX_W'(HIST_DEPTH - 1)) ? '0
                                                            : head_r + HIST_IDX_W'(1);
          dn_r    <= ACC_W'($unsigned(total_abs));
          dvd_r   <= ACC_W'(cnt_nxt);
          neg_r   <= total_nxt < 0;
          rem_r   <= '0;
          q_r     <= '0;
          ovf_r   <= 1'b0;
          it_r    <= 8'd64;
          ph_r    <= P_MEAN;
          state_r <= S_DIV;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DIV) && (it_r == 8'd1) && (ph_r == P_MEAN)) begin
      out_correlation      <= corr_r;
      out_balance          <= bal_r;
      out_mean_correlation <= neg_r ? negq[15:0] : $signed(q_nxt[15:0]);
    end
  end

  `SCM_ASSERT_ALWAYS(a_cnt_range, cnt_r <= CNT_W'(HIST_DEPTH))
  `SCM_ASSERT_ALWAYS(a_head_range, head_r < HIST_IDX_W'(HIST_DEPTH))
  `SCM_ASSERT_IMPLY(a_div_nonzero, state_r == S_DIV, dvd_r != '0)
  `SCM_ASSERT_IMPLY(a_out_filled, out_valid_r, cnt_r != '0)

endmodule

>>> tb/tb_stereo_correlation_meter_top.sv
// Testbench for the stereo correlation meter: directed table, random buffers, predictor.
`timescale 1ns / 1ps

module tb_stereo_correlation_meter_top;
  import scm_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int DRAIN_CYCLES = 600;
  localparam int RAND_PER_PHASE = 220;
  localparam int NUM_PHASES = 9;

  typedef struct packed {
    logic [15:0] corr;
    logic [15:0] bal;
    logic [15:0] mean;
    logic [5:0]  fill;
  } meter_res_t;

  typedef struct {
    kind_t       kind;
    logic [23:0] smp;
    bit          last;
    bit          typed;
    meter_res_t  res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic in_kind;
  logic signed [23:0] in_sample;
  logic in_last;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] out_correlation;
  logic signed [15:0] out_balance;
  logic signed [15:0] out_mean_correlation;
  logic [5:0] out_history_fill;

  stereo_correlation_meter_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind), .in_sample(in_sample),
    .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_correlation(out_correlation),
    .out_balance(out_balance), .out_mean_correlation(out_mean_correlation),
    .out_history_fill(out_history_fill)
  );

  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  meter_res_t expected_results[$];

  // predictor state
  logic [3:0] chan_count_reg;
  logic [2:0] x_sel;
  logic [2:0] y_sel;
  longint unsigned acc_ex;
  longint unsigned acc_ey;
  longint acc_cs;
  int frame_pos;
  longint held_x;
  longint held_y;
  int frames_in_buf;
  int hist_ring[HIST_DEPTH];
  int hist_head;
  int hist_count;
  int hist_total;

  dir_row_t dir_rows[18] = '{
    '{KIND_SAMPLE, 24'h000000, 1'b1, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 6'd1}},
    '{KIND_CLEAR,  24'h5A5A5A, 1'b1, 1'b0, '0},
    '{KIND_SAMPLE, 24'h7FFFFF, 1'b0, 1'b0, '0},
    '{KIND_SAMPLE, 24'h7FFFFF, 1'b1, 1'b0, '0},
    '{KIND_SAMPLE, 24'h800000, 1'b0, 1'b0, '0},
    '{KIND_SAMPLE, 24'h7FFFFF, 1'b1, 1'b0, '0},
    '{KIND_SAMPLE, 24'h800000, 1'b0, 1'b0, '0},
    '{KIND_SAMPLE, 24'h800000, 1'b1, 1'b0, '0},
    '{KIND_SAMPLE, 24'h000000, 1'b0, 1'b0, '0},
    '{KIND_SAMPLE, 24'h001234, 1'b1, 1'b0, '0},
    '{KIND_SAMPLE, 24'hFFFFFF, 1'b1, 1'b0, '0},
    '{KIND_CLEAR,  24'hA5A5A5, 1'b0, 1'b0, '0},
    '{KIND_SAMPLE, 24'h000000, 1'b1, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 6'd1}},
    '{KIND_SAMPLE, 24'h000005, 1'b0, 1'b0, '0},
    '{KIND_CLEAR,  24'hFFFFFF, 1'b1, 1'b0, '0},
    '{KIND_SAMPLE, 24'h000007, 1'b1, 1'b0, '0},
    '{KIND_SAMPLE, 24'h000100, 1'b0, 1'b0, '0},
    '{KIND_SAMPLE, 24'hFFFF00, 1'b1, 1'b0, '0}
  };

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned scaled_quotient(longint unsigned num,
                                                      longint unsigned den, int bits, bit lim);
    longint unsigned q;
    longint unsigned rem;
    q = num / den;
    rem = num % den;
    for (int i = 0; i < bits; i++) begin
      if (lim && q >= 65536) break;
      rem <<= 1;
      q <<= 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic int buffer_correlation();
    int k;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned mag;
    longint unsigned q;
    k = 0;
    if (acc_ex == 0 || acc_ey == 0) return 0;
    ax = acc_ex;
    ay = acc_ey;
    while (ax < (64'd1 << 60)) begin
      ax <<= 2;
      k++;
    end
    while (ay < (64'd1 << 60)) begin
      ay <<= 2;
      k++;
    end
    mag = (acc_cs < 0) ? longint'(-acc_cs) : longint'(acc_cs);
    q = scaled_quotient(mag, isqrt(ax) * isqrt(ay), 15 + k, 1'b1);
    if (acc_cs < 0) return (q > 32768) ? -32768 : -int'(q);
    return (q > 32767) ? 32767 : int'(q);
  endfunction

  function automatic int buffer_balance();
    bit y_louder;
    longint unsigned r;
    y_louder = acc_ey > acc_ex;
    if (acc_ex == 0 && acc_ey == 0) return 0;
    if (y_louder) begin
      r = isqrt(scaled_quotient(acc_ex, acc_ey, 30, 1'b0));
      return (32768 - r > 32767) ? 32767 : int'(32768 - r);
    end
    r = isqrt(scaled_quotient(acc_ey, acc_ex, 30, 1'b0));
    return int'(r) - 32768;
  endfunction

  function automatic void predictor_reset();
    chan_count_reg = 4'd2;
    x_sel = 3'd0;
    y_sel = 3'd1;
    acc_ex = 0;
    acc_ey = 0;
    acc_cs = 0;
    frame_pos = 0;
    held_x = 0;
    held_y = 0;
    frames_in_buf = 0;
    hist_head = 0;
    hist_count = 0;
    hist_total = 0;
  endfunction

  // returns 1 when the beat closes a buffer
  function automatic bit meter_step(kind_t kind, logic [23:0] smp, bit last,
                                    output meter_res_t res);
    int cc;
    bit frame_end;
    int corr;
    int bal;
    longint s;
    res = '0;
    if (kind == KIND_CLEAR) begin
      hist_head = 0;
      hist_count = 0;
      hist_total = 0;
      return 0;
    end
    s = longint'($signed(smp));
    cc = chan_count_reg;
    if (cc == 0) cc = 1;
    if (cc > MAX_CH) cc = MAX_CH;
    if (frame_pos >= cc) frame_pos = 0;
    if (frame_pos == x_sel) held_x = s;
    if (frame_pos == y_sel) held_y = s;
    frame_end = (frame_pos == cc - 1) || last;
    if (frame_end) begin
      if (frames_in_buf < MAX_FRAMES) begin
        acc_ex += longint'(held_x * held_x);
        acc_ey += longint'(held_y * held_y);
        acc_cs += held_x * held_y;
        frames_in_buf++;
      end
      held_x = 0;
      held_y = 0;
      frame_pos = 0;
    end else begin
      frame_pos++;
    end
    if (!last) return 0;
    corr = buffer_correlation();
    bal = buffer_balance();
    if (hist_count >= HIST_DEPTH) hist_total -= hist_ring[hist_head];
    else hist_count++;
    hist_ring[hist_head] = corr;
    hist_total += corr;
    hist_head = (hist_head + 1) % HIST_DEPTH;
    acc_ex = 0;
    acc_ey = 0;
    acc_cs = 0;
    frames_in_buf = 0;
    res.corr = corr[15:0];
    res.bal = bal[15:0];
    res.mean = 16'(hist_total / hist_count);
    res.fill = hist_count[5:0];
    return 1;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    meter_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("unexpected beat", out_correlation, 16'h0);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_correlation !== want.corr) report("correlation", out_correlation, want.corr);
        if (out_balance !== want.bal) report("balance", out_balance, want.bal);
        if (out_mean_correlation !== want.mean)
          report("mean_correlation", out_mean_correlation, want.mean);
        if (out_history_fill !== want.fill)
          report("history_fill", 16'(out_history_fill), 16'(want.fill));
      end
    end
  end

  task automatic send_beat(kind_t kind, logic [23:0] smp, bit last, bit typed,
                           meter_res_t typed_res);
    meter_res_t res;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_sample <= smp;
    in_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (meter_step(kind, smp, last, res))
      expected_results.insert(expected_results.size(), typed ? typed_res : res);
    @(negedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CHANNEL_COUNT: chan_count_reg = val;
      CFG_X_CHANNEL: x_sel = val[2:0];
      CFG_Y_CHANNEL: y_sel = val[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [23:0] pick_sample();
    logic [23:0] v;
    case ($urandom_range(5))
      0: v = 24'h7FFFFF;
      1: v = 24'h800000;
      2: begin
        v = 24'($urandom_range(255));
        if ($urandom_range(1)) v = -v;
      end
      default: v = 24'($urandom);
    endcase
    return v;
  endfunction

  logic [3:0] phase_cc[NUM_PHASES] = '{4'd2, 4'd1, 4'd8, 4'd0, 4'd15, 4'd4, 4'd3, 4'd8, 4'd1};
  logic [3:0] phase_x[NUM_PHASES]  = '{4'd0, 4'd0, 4'd7, 4'd0, 4'd6, 4'd5, 4'd2, 4'd0, 4'd0};
  logic [3:0] phase_y[NUM_PHASES]  = '{4'd1, 4'd0, 4'd0, 4'd5, 4'd7, 4'd2, 4'd3, 4'd7, 4'd0};

  initial begin
    kind_t k;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CHANNEL_COUNT;
    cfg_data = 4'd0;
    in_valid = 1'b0;
    in_kind = KIND_SAMPLE;
    in_sample = '0;
    in_last = 1'b0;
    predictor_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle = (p < 3) ? 34 : (p < 6) ? 57 : 0;
      recv_idle = (p < 3) ? 57 : (p < 6) ? 34 : 0;
      if (p > 0) drain();
      cfg_write(CFG_CHANNEL_COUNT, phase_cc[p]);
      cfg_write(CFG_X_CHANNEL, phase_x[p]);
      cfg_write(CFG_Y_CHANNEL, phase_y[p]);
      if (p == 0) begin
        foreach (dir_rows[i])
          send_beat(dir_rows[i].kind, dir_rows[i].smp, dir_rows[i].last,
                    dir_rows[i].typed, dir_rows[i].res);
      end
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        k = ($urandom_range(149) == 0) ? KIND_CLEAR : KIND_SAMPLE;
        send_beat(k, pick_sample(), ($urandom_range(7) == 0), 1'b0, '0);
      end
    end
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
